[src/ptfa_pkg.sv]
// Shared types and constants for the page table first-fit allocator.
// No dependencies.
package ptfa_pkg;
   localparam int NUM_TABLES = 4;
   localparam int PAGES_PER_TABLE = 1024;
   typedef enum logic [3:0] {
      OP_MAP = 4'd0, OP_LOOKUP = 4'd1, OP_SET_FLAGS = 4'd2, OP_SET_PRESENT = 4'd3,
      OP_SET_ABSENT = 4'd4, OP_GET_DIR = 4'd5, OP_SET_DIR = 4'd6, OP_ALLOC = 4'd7,
      OP_COUNT = 4'd8, OP_INIT = 4'd9
   } op_type;
   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_OOM = 2'd1, ST_RANGE = 2'd2, ST_ZERO = 2'd3
   } status_type;
   localparam logic [11:0] FLAG_PRESENT = 12'h001;
   localparam logic [11:0] FLAG_RW = 12'h002;
endpackage

[src/page_table_first_fit_allocator.sv]
// Top level: page table, directory flags and a sequencer that walks entries.
// Depends on ptfa_pkg.
// Map, get_dir and rejected commands respond straight from the check; lookup goes through
// S_RD, S_WAIT and S_MOD; run commands read, modify and write each page; set_dir writes
// each directory; init, count and alloc walk the table. One request at a time.
// Reset: synchronous; a clearing pass over every entry refills the table.
module page_table_first_fit_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [11:0] csr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   // op[3:0], virt_addr[35:4], phys_addr[67:36], flag_bits[79:68], run_length[92:80]
   input  logic [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[1:0], result_addr[33:2], result_flags[45:34], used_pages[58:46]
   output logic [63:0] rsp_tdata
);
   import ptfa_pkg::*;
   localparam int TOTAL = NUM_TABLES * PAGES_PER_TABLE;
   localparam int AW = $clog2(TOTAL);
   localparam int DW = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
   localparam int CW = AW + 1;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_CHECK, S_RD, S_WAIT, S_MOD, S_SCAN_RD, S_SCAN,
      S_DIR, S_RESP
   } state_type;

   logic [31:0] mem [TOTAL];
   logic [11:0] dir_ff [NUM_TABLES];
   state_type   state_ff;
   logic [11:0] kend_ff;
   logic [3:0]  op_ff;
   logic [31:0] va_ff, pa_ff;
   logic [11:0] fl_ff;
   logic [12:0] len_ff;
   logic [CW-1:0] idx_ff, end_ff, start_ff, streak_ff, used_ff;
   logic        fill_kern_ff;
   logic [31:0] rd_ff;
   logic        we_ff;
   logic [AW-1:0] wa_ff;
   logic [31:0] wd_ff;
   logic [1:0]  st_ff;
   logic [31:0] raddr_ff;
   logic [11:0] rflags_ff;
   logic [12:0] used_out_ff;
   logic        rsp_valid_ff;

   logic [19:0] pg;
   logic [9:0]  dir;
   logic [20:0] pg_end;
   logic [13:0] dir_end;
   logic        pg_over;
   assign pg = va_ff[31:12];
   assign dir = va_ff[31:22];
   assign pg_end = {1'b0, pg} + {8'd0, len_ff};
   assign dir_end = {4'd0, dir} + {1'b0, len_ff};
   assign pg_over = {12'd0, pg} >= 32'(TOTAL);

   assign csr_ready = 1'b1;
   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {5'd0, used_out_ff, rflags_ff, raddr_ff, st_ff};

   function automatic logic [31:0] ident(input logic [CW-1:0] i);
      logic [31:0] v;
      v = 32'd0;
      v[12 +: AW] = i[AW-1:0];
      return v | {20'd0, FLAG_RW};
   endfunction

   always_ff @(posedge clock) begin
      if (we_ff) mem[wa_ff] <= wd_ff;
      rd_ff <= mem[idx_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      we_ff <= !reset && ((state_ff == S_CLEAR) ||
                          (state_ff == S_CHECK && op_ff == OP_MAP && !pg_over) ||
                          (state_ff == S_MOD && op_ff != OP_LOOKUP));
      if (reset) begin
         state_ff <= S_CLEAR;
         kend_ff <= 12'd0;
         idx_ff <= '0;
         fill_kern_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int d = 0; d < NUM_TABLES; d++) dir_ff[d] <= FLAG_RW | FLAG_PRESENT;
      end else begin
         if (csr_valid) kend_ff <= csr_data;
         if (state_ff == S_RESP) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               wa_ff <= idx_ff[AW-1:0];
               wd_ff <= ident(idx_ff) |
                  ((fill_kern_ff && idx_ff <= CW'(kend_ff)) ? 32'd1 : 32'd0);
               if (idx_ff == CW'(TOTAL - 1)) state_ff <= fill_kern_ff ? S_RESP : S_IDLE;
               idx_ff <= idx_ff + 1'b1;
            end
            S_IDLE: if (req_tvalid && !rsp_valid_ff) begin
               op_ff <= req_tdata[3:0];
               va_ff <= req_tdata[35:4];
               pa_ff <= req_tdata[67:36];
               fl_ff <= req_tdata[79:68];
               len_ff <= req_tdata[92:80];
               st_ff <= ST_OK;
               raddr_ff <= 32'd0;
               rflags_ff <= 12'd0;
               used_out_ff <= 13'd0;
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               end_ff <= pg_end[CW-1:0];
               case (op_ff)
                  OP_MAP: begin
                     if (pg_over) st_ff <= ST_RANGE;
                     else begin
                        wa_ff <= pg[AW-1:0];
                        wd_ff <= pa_ff | {20'd0, fl_ff};
                     end
                     state_ff <= S_RESP;
                  end
                  OP_LOOKUP: begin
                     idx_ff <= pg[CW-1:0];
                     if (pg_over) begin st_ff <= ST_RANGE; state_ff <= S_RESP; end
                     else state_ff <= S_RD;
                  end
                  OP_SET_FLAGS, OP_SET_PRESENT, OP_SET_ABSENT: begin
                     idx_ff <= pg[CW-1:0];
                     if (len_ff == 13'd0) begin st_ff <= ST_ZERO; state_ff <= S_RESP; end
                     else if ({11'd0, pg_end} > 32'(TOTAL)) begin
                        st_ff <= ST_RANGE;
                        state_ff <= S_RESP;
                     end else state_ff <= S_RD;
                  end
                  OP_GET_DIR: begin
                     if ({22'd0, dir} >= 32'(NUM_TABLES)) st_ff <= ST_RANGE;
                     else rflags_ff <= dir_ff[dir[DW-1:0]];
                     state_ff <= S_RESP;
                  end
                  OP_SET_DIR: begin
                     idx_ff <= CW'(dir);
                     if (len_ff == 13'd0) begin st_ff <= ST_ZERO; state_ff <= S_RESP; end
                     else if ({18'd0, dir_end} > 32'(NUM_TABLES)) begin
                        st_ff <= ST_RANGE;
                        state_ff <= S_RESP;
                     end else state_ff <= S_DIR;
                  end
                  OP_ALLOC: begin
                     idx_ff <= '0; start_ff <= '0; streak_ff <= '0;
                     if (len_ff == 13'd0) begin st_ff <= ST_ZERO; state_ff <= S_RESP; end
                     else state_ff <= S_SCAN_RD;
                  end
                  OP_COUNT: begin idx_ff <= '0; used_ff <= '0; state_ff <= S_SCAN_RD; end
                  OP_INIT: begin
                     idx_ff <= '0; fill_kern_ff <= 1'b1; state_ff <= S_CLEAR;
                     for (int d = 0; d < NUM_TABLES; d++) dir_ff[d] <= FLAG_RW | FLAG_PRESENT;
                  end
                  default: state_ff <= S_RESP;
               endcase
            end
            S_RD: state_ff <= S_WAIT;
            S_WAIT: state_ff <= S_MOD;
            S_MOD: begin
               wa_ff <= idx_ff[AW-1:0];
               case (op_ff)
                  OP_LOOKUP: begin
                     raddr_ff <= rd_ff & 32'hFFFFF000;
                     rflags_ff <= rd_ff[11:0];
                  end
                  OP_SET_FLAGS: wd_ff <= (rd_ff & 32'hFFFFF000) | {20'd0, fl_ff};
                  OP_SET_ABSENT: wd_ff <= rd_ff & 32'hFFFFFFFE;
                  default: wd_ff <= rd_ff | 32'd1;
               endcase
               if (op_ff == OP_LOOKUP) state_ff <= S_RESP;
               else begin
                  idx_ff <= idx_ff + 1'b1;
                  state_ff <= (idx_ff + 1'b1 == end_ff) ? S_RESP : S_RD;
               end
            end
            S_SCAN_RD: begin idx_ff <= idx_ff + 1'b1; state_ff <= S_SCAN; end
            S_SCAN: begin
               // rd_ff holds entry idx_ff-1
               if (op_ff == OP_COUNT) begin
                  idx_ff <= idx_ff + 1'b1;
                  if (rd_ff[0]) used_ff <= used_ff + 1'b1;
                  if (idx_ff == CW'(TOTAL)) begin
                     used_out_ff <= 13'(used_ff + CW'(rd_ff[0]));
                     state_ff <= S_RESP;
                  end
               end else if (!rd_ff[0] && {{(32-CW){1'b0}}, streak_ff + 1'b1} == 32'(len_ff)) begin
                  idx_ff <= start_ff;
                  end_ff <= start_ff + CW'(len_ff);
                  raddr_ff <= {{(20-CW){1'b0}}, start_ff, 12'd0};
                  state_ff <= S_RD;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
                  if (rd_ff[0]) begin streak_ff <= '0; start_ff <= idx_ff; end
                  else streak_ff <= streak_ff + 1'b1;
                  if (idx_ff == CW'(TOTAL)) begin st_ff <= ST_OOM; state_ff <= S_RESP; end
               end
            end
            S_DIR: begin
               dir_ff[idx_ff[DW-1:0]] <= fl_ff;
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff + 1'b1 == CW'(dir_end)) state_ff <= S_RESP;
            end
            S_RESP: begin
               fill_kern_ff <= 1'b0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

[tb/tb_page_table_first_fit_allocator.sv]
// Self-checking testbench for page_table_first_fit_allocator: a behavioral copy of
// the page table and directory flags predicts every response. Depends on ptfa_pkg
// and the top level only.
module tb_page_table_first_fit_allocator;
   timeunit 1ns;
   timeprecision 1ps;
   import ptfa_pkg::*;

   localparam int TOTAL_PAGES = 4096;
   localparam int NUM_DIRS = 4;
   localparam logic [31:0] FRAME_MASK = 32'hFFFF_F000;

   typedef struct {
      logic [3:0]  op;
      logic [31:0] virt_addr;
      logic [31:0] phys_addr;
      logic [11:0] flag_bits;
      logic [12:0] run_length;
   } command_type;

   typedef struct {
      status_type  status;
      logic [31:0] result_addr;
      logic [11:0] result_flags;
      logic [12:0] used_pages;
   } response_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [11:0] csr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;

   page_table_first_fit_allocator u_top (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #5 clock = ~clock;

   logic [31:0] frame_entries [TOTAL_PAGES];
   logic [11:0] dir_words [NUM_DIRS];
   logic [11:0] kernel_end;

   command_type  pending_requests [$];
   response_type expected_results [$];
   command_type  driven_cmd;
   bit        req_fire = 0;
   bit        failed = 0;
   int        accepted = 0;
   int        hold_left = 0;
   bit        held = 0;
   wire       calm = (accepted >= 70 && accepted < 100);

   function automatic void refill_tables();
      for (int k = 0; k < TOTAL_PAGES; k++) frame_entries[k] = (k * 32'h1000) | 32'(FLAG_RW);
      for (int d = 0; d < NUM_DIRS; d++) dir_words[d] = FLAG_RW | FLAG_PRESENT;
   endfunction

   function automatic response_type apply_command(command_type c);
      response_type r;
      int unsigned pg, dir, len, streak, start, last;
      bit found;
      r = '{ST_OK, 32'd0, 12'd0, 13'd0};
      pg = c.virt_addr >> 12;
      dir = c.virt_addr >> 22;
      len = c.run_length;
      case (c.op)
         OP_MAP, OP_LOOKUP: begin
            if (pg >= TOTAL_PAGES) r.status = ST_RANGE;
            else if (c.op == OP_MAP) frame_entries[pg] = c.phys_addr | 32'(c.flag_bits);
            else begin
               r.result_addr = frame_entries[pg] & FRAME_MASK;
               r.result_flags = frame_entries[pg][11:0];
            end
         end
         OP_SET_FLAGS, OP_SET_PRESENT, OP_SET_ABSENT: begin
            if (len == 0) r.status = ST_ZERO;
            else if (pg + len > TOTAL_PAGES) r.status = ST_RANGE;
            else
               for (int unsigned k = pg; k < pg + len; k++)
                  if (c.op == OP_SET_FLAGS)
                     frame_entries[k] = (frame_entries[k] & FRAME_MASK) | 32'(c.flag_bits);
                  else
                     frame_entries[k][0] = (c.op == OP_SET_PRESENT);
         end
         OP_GET_DIR: begin
            if (dir >= NUM_DIRS) r.status = ST_RANGE;
            else r.result_flags = dir_words[dir];
         end
         OP_SET_DIR: begin
            if (len == 0) r.status = ST_ZERO;
            else if (dir + len > NUM_DIRS) r.status = ST_RANGE;
            else for (int unsigned k = dir; k < dir + len; k++) dir_words[k] = c.flag_bits;
         end
         OP_ALLOC: begin
            streak = 0; start = 0; found = 0;
            if (len == 0) r.status = ST_ZERO;
            else begin
               for (int unsigned k = 0; k < TOTAL_PAGES && !found; k++) begin
                  if (!frame_entries[k][0]) streak++;
                  else begin
                     streak = 0;
                     start = k + 1;
                  end
                  if (streak == len) found = 1;
               end
               if (!found) r.status = ST_OOM;
               else begin
                  for (int unsigned k = start; k < start + len; k++) frame_entries[k][0] = 1'b1;
                  r.result_addr = start * 32'h1000;
               end
            end
         end
         OP_COUNT: begin
            for (int k = 0; k < TOTAL_PAGES; k++) r.used_pages += frame_entries[k][0];
         end
         OP_INIT: begin
            last = kernel_end + 1;
            refill_tables();
            if (last > TOTAL_PAGES) last = TOTAL_PAGES;
            for (int unsigned k = 0; k < last; k++) frame_entries[k][0] = 1'b1;
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic command_type make_cmd(logic [3:0] op, logic [31:0] va, logic [31:0] pa,
                                            logic [11:0] fl, logic [12:0] len);
      command_type c;
      c.op = op; c.virt_addr = va; c.phys_addr = pa; c.flag_bits = fl; c.run_length = len;
      return c;
   endfunction

   function automatic command_type random_cmd();
      logic [3:0]  op;
      logic [31:0] va;
      logic [12:0] len;
      int          pick;
      pick = $urandom_range(99);
      if (pick < 4) op = 4'($urandom_range(15, 10));
      else if (pick < 8) op = OP_INIT;
      else op = 4'($urandom_range(8));
      pick = $urandom_range(99);
      if (pick < 10) va = $urandom;
      else if (pick < 20) va = 32'($urandom_range(TOTAL_PAGES - 1, TOTAL_PAGES - 40)) << 12;
      else va = {8'd0, 12'($urandom_range(4095)), 12'($urandom)};
      pick = $urandom_range(99);
      if (pick < 5) len = 13'd0;
      else if (pick < 12) len = 13'($urandom_range(4096));
      else len = 13'($urandom_range(24, 1));
      if (op == OP_SET_DIR && pick >= 12) len = 13'($urandom_range(4, 1));
      return make_cmd(op, va, $urandom, 12'($urandom), len);
   endfunction

   always @(posedge clock) begin
      response_type want, got;
      req_fire = req_tvalid && req_tready;
      if (req_fire) begin
         expected_results.push_back(apply_command(driven_cmd));
         accepted++;
      end
      if (rsp_tvalid && rsp_tready) begin
         got.status = status_type'(rsp_tdata[1:0]);
         got.result_addr = rsp_tdata[33:2];
         got.result_flags = rsp_tdata[45:34];
         got.used_pages = rsp_tdata[58:46];
         if (expected_results.size() == 0) begin
            $display("%0t: response with none expected: %h", $time, rsp_tdata);
            failed = 1;
         end else begin
            want = expected_results.pop_front();
            if (got.status != want.status) begin
               $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
               failed = 1;
            end
            if (got.result_addr != want.result_addr) begin
               $display("%0t: addr exp %h got %h", $time, want.result_addr, got.result_addr);
               failed = 1;
            end
            if (got.result_flags != want.result_flags) begin
               $display("%0t: flags exp %h got %h", $time, want.result_flags,
                        got.result_flags);
               failed = 1;
            end
            if (got.used_pages != want.used_pages) begin
               $display("%0t: used exp %0d got %0d", $time, want.used_pages, got.used_pages);
               failed = 1;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_fire)) begin
         if (pending_requests.size() > 0 && (calm || $urandom_range(99) >= 30)) begin
            driven_cmd = pending_requests.pop_front();
            req_tdata <= {3'b0, driven_cmd.run_length, driven_cmd.flag_bits,
                          driven_cmd.phys_addr, driven_cmd.virt_addr, driven_cmd.op};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (accepted >= 30 && !held) begin
         held = 1;
         hold_left = 400;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || $urandom_range(99) >= 30;
      end
   end

   task automatic write_kernel_end(logic [11:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      kernel_end = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_requests.size() > 0 || expected_results.size() > 0 || req_tvalid);
      repeat (10) @(negedge clock);
   endtask

   initial begin
      logic [11:0] kernel_settings [3];
      refill_tables();
      kernel_end = '0;
      kernel_settings[0] = 12'd0;
      kernel_settings[1] = 12'd4095;
      kernel_settings[2] = 12'($urandom_range(200, 1));
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < 3; phase++) begin
         write_kernel_end(kernel_settings[phase]);
         pending_requests.push_back(make_cmd(OP_INIT, 0, 0, 0, 0));
         if (phase == 2) begin
            pending_requests.push_back(make_cmd(OP_COUNT, 0, 0, 0, 0));
            pending_requests.push_back(make_cmd(OP_MAP, 32'hFFFF_FFFF, 0, 12'hFFF, 0));
            pending_requests.push_back(make_cmd(OP_MAP, 32'h0000_5000, 32'hFFFF_FFFF,
                                                12'hFFF, 13'h1FFF));
            pending_requests.push_back(make_cmd(OP_LOOKUP, 32'h0000_5FFF, 0, 0, 0));
            pending_requests.push_back(make_cmd(OP_LOOKUP, 32'h0100_0000, 0, 0, 0));
            pending_requests.push_back(make_cmd(OP_SET_FLAGS, 32'h0000_7000, 0, 12'h555, 0));
            pending_requests.push_back(make_cmd(OP_SET_FLAGS, 32'h00FF_F000, 0, 12'hAAA, 2));
            pending_requests.push_back(make_cmd(OP_SET_FLAGS, 32'h00FF_E000, 0, 12'hAAA, 2));
            pending_requests.push_back(make_cmd(OP_SET_PRESENT, 0, 0, 0, 13'd4096));
            pending_requests.push_back(make_cmd(OP_COUNT, 0, 0, 0, 0));
            pending_requests.push_back(make_cmd(OP_ALLOC, 0, 0, 0, 1));
            pending_requests.push_back(make_cmd(OP_SET_ABSENT, 0, 0, 0, 13'd4096));
            pending_requests.push_back(make_cmd(OP_ALLOC, 0, 0, 0, 13'd4096));
            pending_requests.push_back(make_cmd(OP_SET_ABSENT, 32'h0010_0000, 0, 0, 0));
            pending_requests.push_back(make_cmd(OP_SET_ABSENT, 32'h0001_0000, 0, 0, 20));
            pending_requests.push_back(make_cmd(OP_ALLOC, 0, 0, 0, 13'd4096));
            pending_requests.push_back(make_cmd(OP_ALLOC, 0, 0, 0, 0));
            pending_requests.push_back(make_cmd(OP_ALLOC, 0, 0, 0, 8));
            pending_requests.push_back(make_cmd(OP_GET_DIR, 32'h00C0_0000, 0, 0, 0));
            pending_requests.push_back(make_cmd(OP_GET_DIR, 32'h0100_0000, 0, 0, 0));
            pending_requests.push_back(make_cmd(OP_SET_DIR, 0, 0, 12'hFFF, 4));
            pending_requests.push_back(make_cmd(OP_SET_DIR, 32'h0040_0000, 0, 12'h0, 4));
            pending_requests.push_back(make_cmd(OP_SET_DIR, 0, 0, 12'h0, 0));
            pending_requests.push_back(make_cmd(OP_GET_DIR, 0, 0, 0, 0));
            pending_requests.push_back(make_cmd(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                                12'hFFF, 13'h1FFF));
         end
         for (int n = 0; n < 36; n++) pending_requests.push_back(random_cmd());
         pending_requests.push_back(make_cmd(OP_COUNT, 0, 0, 0, 0));
         drain();
      end
      repeat (50) @(posedge clock);
      if (!failed) $display("page_table_first_fit_allocator: match");
      else $display("page_table_first_fit_allocator: mismatch");
      $finish;
   end

   initial begin
      #100ms;
      $display("page_table_first_fit_allocator: mismatch");
      $finish;
   end
endmodule
